// ===== design/assert_macros.svh =====
// Assertion macros of the bitmap block allocator; used by the controller.
// No dependencies; included by the files that hold assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define BBA_ASSERT_IMP(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("bba assertion failed");
`define BBA_ASSERT_NEXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("bba assertion failed");
`else
`define BBA_ASSERT_IMP(label, clk, rstn, a, b)
`define BBA_ASSERT_NEXT(label, clk, rstn, a, b)
`endif
`endif

// ===== design/bba_pkg.sv =====
// Types, constants and helper functions of the bitmap block allocator.
// No dependencies; imported by the datapath, controller, top level and testbench.
package bba_pkg;
    localparam int MapWords  = 1024;
    localparam int WordAw    = 10;
    localparam logic [16:0] HeapMax = 17'd65536;
    localparam logic [16:0] CountMax = 17'd131071;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NO_SPACE  = 2'd1,
        STATUS_ZERO_SIZE = 2'd2,
        STATUS_RANGE     = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_DECIDE, ST_SCAN_RD, ST_SCAN_EV,
        ST_CHK_RD, ST_CHK_EV, ST_WR_RD, ST_WR_EV, ST_FINISH
    } state_t;

    typedef struct packed {
        logic    clr_we;
        logic    load_item;
        logic    scan_init;
        logic    cand_next;
        logic    cand_to_pos;
        logic    free_init;
        logic    pos_advance;
        logic    run_restart;
        logic    rd_sel_pos;
        logic    wr_en;
        logic    count_upd;
        logic    set_status;
        status_t status;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_free;
        logic zero_size;
        logic free_ok;
        logic word_full;
        logic scan_fit;
        logic cand_last;
        logic conflict;
        logic run_done;
    } stat_t;

    function automatic logic [63:0] span_mask(input logic [5:0] lo, input logic [6:0] cnt);
        logic [63:0] m;
        m = (cnt[6]) ? '1 : ((64'd1 << cnt[5:0]) - 64'd1);
        return m << lo;
    endfunction

    function automatic logic [5:0] lowest_zero(input logic [63:0] w);
        logic [5:0] r;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            if (!w[i])
            begin
                r = 6'(i);
            end
        end
        return r;
    endfunction
endpackage

// ===== design/bba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== design/bba_datapath.sv =====
// Datapath: item registers, run walker, bitmap memory and result register.
// Depends on bba_pkg and bba_ram.
module bba_datapath
    import bba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  logic        item_command,
    input  logic [20:0] item_bytes,
    input  logic [15:0] item_block,
    input  logic [16:0] heap_blocks,
    output logic [1:0]  status,
    output logic [15:0] granted_block,
    output logic [16:0] used_blocks
);
    logic [WordAw-1:0] clr_reg, cand_reg;
    logic              free_reg, zero_reg;
    logic [17:0]       n_reg, left_reg;
    logic [15:0]       block_reg, start_reg;
    logic [16:0]       pos_reg, used_reg;
    status_t           status_reg;
    logic [63:0]       rd_data, wr_data, mask;
    logic [16:0]       lim;
    logic [5:0]        bit_pos, lz;
    logic [6:0]        avail, take;
    logic [15:0]       scan_start;
    logic [18:0]       sum_add;
    logic              we;
    logic [WordAw-1:0] waddr, raddr;

    assign lim        = (heap_blocks > HeapMax) ? HeapMax : heap_blocks;
    assign bit_pos    = pos_reg[5:0];
    assign avail      = 7'd64 - {1'b0, bit_pos};
    assign take       = ({11'd0, avail} <= left_reg) ? avail : left_reg[6:0];
    assign mask       = span_mask(bit_pos, take);
    assign lz         = lowest_zero(rd_data);
    assign scan_start = {cand_reg, lz};
    assign sum_add    = {1'b0, used_reg} + {1'b0, n_reg};

    assign stat.clr_last  = (clr_reg == WordAw'(MapWords - 1));
    assign stat.is_free   = free_reg;
    assign stat.zero_size = zero_reg;
    assign stat.free_ok   = ({3'd0, block_reg} + {1'b0, n_reg}) <= {2'd0, lim};
    assign stat.word_full = &rd_data;
    assign stat.scan_fit  = ({3'd0, scan_start} + {1'b0, n_reg}) <= {2'd0, lim};
    assign stat.cand_last = (cand_reg == WordAw'(MapWords - 1));
    assign stat.conflict  = |(rd_data & mask);
    assign stat.run_done  = (left_reg == {11'd0, take});

    assign we      = cmd.clr_we | cmd.wr_en;
    assign waddr   = cmd.clr_we ? clr_reg : pos_reg[15:6];
    assign raddr   = cmd.rd_sel_pos ? pos_reg[15:6] : cand_reg;
    assign wr_data = cmd.clr_we ? '0 : (free_reg ? (rd_data & ~mask) : (rd_data | mask));

    bba_ram #(.WIDTH(64), .DEPTH(MapWords)) u_map (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wr_data),
        .raddr (raddr),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            used_reg <= '0;
        end
        else
        begin
            if (cmd.clr_we)
            begin
                clr_reg <= clr_reg + WordAw'(1);
            end
            if (cmd.count_upd)
            begin
                if (free_reg)
                begin
                    used_reg <= ({1'b0, used_reg} > n_reg) ? 17'(used_reg - n_reg[16:0]) : '0;
                end
                else
                begin
                    used_reg <= (sum_add > {2'd0, CountMax}) ? CountMax : sum_add[16:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            free_reg   <= item_command;
            zero_reg   <= (item_bytes == '0);
            n_reg      <= 18'(({1'b0, item_bytes} + 22'd23) >> 4);
            block_reg  <= item_block;
            status_reg <= STATUS_OK;
        end
        if (cmd.set_status)
        begin
            status_reg <= cmd.status;
        end
        if (cmd.scan_init)
        begin
            cand_reg <= '0;
        end
        if (cmd.cand_next)
        begin
            cand_reg <= cand_reg + WordAw'(1);
        end
        if (cmd.cand_to_pos)
        begin
            start_reg <= scan_start;
            pos_reg   <= {1'b0, scan_start};
            left_reg  <= n_reg;
        end
        if (cmd.free_init)
        begin
            start_reg <= block_reg;
            pos_reg   <= {1'b0, block_reg};
            left_reg  <= n_reg;
        end
        if (cmd.pos_advance)
        begin
            pos_reg  <= pos_reg + {10'd0, take};
            left_reg <= left_reg - {11'd0, take};
        end
        if (cmd.run_restart)
        begin
            pos_reg  <= {1'b0, start_reg};
            left_reg <= n_reg;
        end
        if (cmd.out_load)
        begin
            status        <= status_reg;
            granted_block <= (!free_reg && status_reg == STATUS_OK) ? start_reg : '0;
            used_blocks   <= used_reg;
        end
    end
endmodule

// ===== design/bba_ctrl.sv =====
// Controller state machine: clearing sweep, first-fit scan, run check and run write.
// Depends on bba_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bba_ctrl
    import bba_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output cmd_t  cmd
);
    state_t state_reg, state_next;
    logic   out_valid_reg;

    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:   if (stat.clr_last) state_next = ST_IDLE;
            ST_IDLE:    if (in_valid) state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                if (stat.is_free)
                    state_next = stat.free_ok ? ST_WR_RD : ST_FINISH;
                else
                    state_next = stat.zero_size ? ST_FINISH : ST_SCAN_RD;
            end
            ST_SCAN_RD: state_next = ST_SCAN_EV;
            ST_SCAN_EV:
            begin
                if (stat.word_full)
                    state_next = stat.cand_last ? ST_FINISH : ST_SCAN_RD;
                else
                    state_next = stat.scan_fit ? ST_CHK_RD : ST_FINISH;
            end
            ST_CHK_RD:  state_next = ST_CHK_EV;
            ST_CHK_EV:
            begin
                if (stat.conflict)
                    state_next = stat.cand_last ? ST_FINISH : ST_SCAN_RD;
                else
                    state_next = stat.run_done ? ST_WR_RD : ST_CHK_RD;
            end
            ST_WR_RD:   state_next = ST_WR_EV;
            ST_WR_EV:   state_next = stat.run_done ? ST_FINISH : ST_WR_RD;
            ST_FINISH:  if (!out_valid_reg || out_ready) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        cmd.status = STATUS_OK;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:   cmd.clr_we = 1'b1;
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            ST_DECIDE:
            begin
                cmd.scan_init = 1'b1;
                cmd.free_init = 1'b1;
                if (stat.is_free && !stat.free_ok)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = STATUS_RANGE;
                end
                else if (!stat.is_free && stat.zero_size)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = STATUS_ZERO_SIZE;
                end
            end
            ST_SCAN_RD: cmd.rd_sel_pos = 1'b0;
            ST_SCAN_EV:
            begin
                if (stat.word_full)
                begin
                    cmd.cand_next  = !stat.cand_last;
                    cmd.set_status = stat.cand_last;
                    cmd.status     = STATUS_NO_SPACE;
                end
                else if (stat.scan_fit)
                begin
                    cmd.cand_to_pos = 1'b1;
                end
                else
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = STATUS_NO_SPACE;
                end
            end
            ST_CHK_RD:  cmd.rd_sel_pos = 1'b1;
            ST_CHK_EV:
            begin
                if (stat.conflict)
                begin
                    cmd.cand_next  = !stat.cand_last;
                    cmd.set_status = stat.cand_last;
                    cmd.status     = STATUS_NO_SPACE;
                end
                else if (stat.run_done)
                begin
                    cmd.run_restart = 1'b1;
                end
                else
                begin
                    cmd.pos_advance = 1'b1;
                end
            end
            ST_WR_RD:   cmd.rd_sel_pos = 1'b1;
            ST_WR_EV:
            begin
                cmd.rd_sel_pos  = 1'b1;
                cmd.wr_en       = 1'b1;
                cmd.pos_advance = 1'b1;
                cmd.count_upd   = stat.run_done;
            end
            ST_FINISH:  cmd.out_load = !out_valid_reg || out_ready;
            default:    cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    `BBA_ASSERT_NEXT(a_accept_decide, clk, rst_n, in_valid && in_ready, state_reg == ST_DECIDE)
    `BBA_ASSERT_IMP(a_clear_blocks, clk, rst_n, state_reg == ST_CLEAR, !in_ready && !out_valid)
    `BBA_ASSERT_NEXT(a_finish_holds, clk, rst_n,
        state_reg == ST_FINISH && out_valid_reg && !out_ready, state_reg == ST_FINISH)
    `BBA_ASSERT_IMP(a_write_in_run, clk, rst_n, cmd.wr_en, !cmd.clr_we && !cmd.load_item)
endmodule

// ===== design/bitmap_block_allocator.sv =====
// Top level of the bitmap block allocator: stream ports, APB register, controller, datapath.
// Depends on bba_pkg, bba_ctrl and bba_datapath.
//
//   Channel   Direction  Word
//   s_*       in         tuser: command; tdata: request_bytes, free_block
//   m_*       out        tdata: status, granted_block, used_blocks
//   APB       in/out     register heap_blocks at address 0
//
// After reset all 1024 bitmap words are swept clear, with no word accepted.
// A free checks its range, then reads and rewrites each bitmap word that the run touches.
// An allocate reads past full words, checks each candidate run word by word, then writes the
// run word by word; the bitmap memory read port sets the pace.
// A new word is taken once the previous result is in the output register.
module bitmap_block_allocator
    import bba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // request_bytes[20:0], free_block[36:21], zero fill
    input  logic [0:0]  s_tuser,  // command[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // status[1:0], granted_block[17:2], used_blocks[34:18]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [16:0] heap_blocks_reg;
    cmd_t        cmd;
    stat_t       stat;
    logic [1:0]  status;
    logic [15:0] granted_block;
    logic [16:0] used_blocks;

    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == 1'b0) ? {15'd0, heap_blocks_reg} : '0;
    assign m_tdata = {5'd0, used_blocks, granted_block, status};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            heap_blocks_reg <= HeapMax;
        else if (psel && penable && pwrite && pready && paddr[2] == 1'b0)
            heap_blocks_reg <= pwdata[16:0];
    end

    bba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bba_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .item_command  (s_tuser[0]),
        .item_bytes    (s_tdata[20:0]),
        .item_block    (s_tdata[36:21]),
        .heap_blocks   (heap_blocks_reg),
        .status        (status),
        .granted_block (granted_block),
        .used_blocks   (used_blocks)
    );
endmodule

// ===== test/bitmap_block_allocator_test.sv =====
// Self-checking testbench of the bitmap block allocator: a directed table, then random phases.
// Depends on bba_pkg and bitmap_block_allocator; results are checked against the table or a local predictor.
module bitmap_block_allocator_test
    import bba_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE = 1'b1;
    localparam logic [2:0] REG_HEAP_BLOCKS = 3'd0;
    localparam int CYCLE_LIMIT = 20000000;

    typedef struct {
        status_t     status;
        logic [15:0] granted;
        logic [16:0] used;
    } result_t;

    typedef struct {
        logic        cmd;
        logic [20:0] bytes;
        logic [15:0] block;
        bit          typed;
        result_t     res;
    } row_t;

    typedef struct {
        int start;
        int bytes;
    } grant_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic [63:0] map_model [MapWords];
    int          used_model;
    int          heap_model;
    result_t     pending_results [$];
    grant_t      live_grants [$];
    int          errors = 0;
    int          cycles = 0;
    bit          calm = 1'b0;
    bit          stall_request = 1'b0;
    int          hold_left = 0;
    int          gap_left = 0;

    bitmap_block_allocator dut (.*);

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected word %h", $realtime, m_tdata);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_tdata[1:0] !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d", $realtime,
                                 want.status, m_tdata[1:0]);
                        errors++;
                    end
                    if (m_tdata[17:2] !== want.granted)
                    begin
                        $display("%0t: granted_block expected %0d actual %0d", $realtime,
                                 want.granted, m_tdata[17:2]);
                        errors++;
                    end
                    if (m_tdata[34:18] !== want.used)
                    begin
                        $display("%0t: used_blocks expected %0d actual %0d", $realtime,
                                 want.used, m_tdata[34:18]);
                        errors++;
                    end
                end
            end
            if (stall_request)
            begin
                stall_request = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!calm && $urandom_range(0, 9) < 2)
                begin
                    gap_left = ($urandom_range(0, 14) == 0) ? $urandom_range(15, 60)
                                                            : $urandom_range(1, 3);
                end
            end
        end
    end

    function automatic int blocks_for(int bytes);
        return (bytes + 23) / 16;
    endfunction

    function automatic int limit_now();
        return (heap_model > 65536) ? 65536 : heap_model;
    endfunction

    function automatic bit span_clear(int start, int n);
        for (int i = start; i < start + n; i++)
        begin
            if (map_model[i >> 6][i & 63])
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic void span_write(int start, int n, logic val);
        for (int i = start; i < start + n; i++)
        begin
            map_model[i >> 6][i & 63] = val;
        end
    endfunction

    function automatic result_t apply_request(logic cmd, int bytes, int block);
        result_t r;
        int n;
        int start;
        int b;
        bit found;
        n = blocks_for(bytes);
        r.status = STATUS_OK;
        r.granted = '0;
        found = 1'b0;
        if (cmd == CMD_ALLOC)
        begin
            if (bytes == 0)
            begin
                r.status = STATUS_ZERO_SIZE;
            end
            else
            begin
                for (int w = 0; w < MapWords && !found; w++)
                begin
                    if (map_model[w] != '1)
                    begin
                        b = 0;
                        while (map_model[w][b])
                        begin
                            b++;
                        end
                        start = w * 64 + b;
                        if (start + n <= limit_now() && span_clear(start, n))
                        begin
                            span_write(start, n, 1'b1);
                            used_model = (used_model + n > 131071) ? 131071 : used_model + n;
                            r.granted = 16'(start);
                            found = 1'b1;
                            live_grants.push_back('{start, bytes});
                        end
                    end
                end
                if (!found)
                begin
                    r.status = STATUS_NO_SPACE;
                end
            end
        end
        else if (block + n <= limit_now())
        begin
            span_write(block, n, 1'b0);
            used_model = (used_model > n) ? used_model - n : 0;
        end
        else
        begin
            r.status = STATUS_RANGE;
        end
        r.used = 17'(used_model);
        return r;
    endfunction

    task automatic send_word(logic cmd, logic [20:0] bytes, logic [15:0] block, bit typed,
                             result_t typed_res);
        int gap;
        result_t r;
        gap = 0;
        if (!calm && $urandom_range(0, 9) < 3)
        begin
            gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {3'b000, block, bytes};
        do @(posedge clk); while (!s_tready);
        r = apply_request(cmd, bytes, block);
        pending_results.push_back(typed ? typed_res : r);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_heap_blocks(int value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_HEAP_BLOCKS;
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        heap_model = value & 32'h1FFFF;
    endtask

    task automatic send_random();
        int pick;
        int idx;
        grant_t g;
        result_t none;
        none = '{STATUS_OK, '0, '0};
        pick = $urandom_range(0, 99);
        if (pick < 30 && live_grants.size() != 0)
        begin
            idx = $urandom_range(0, live_grants.size() - 1);
            g = live_grants[idx];
            live_grants.delete(idx);
            send_word(CMD_FREE, 21'(g.bytes), 16'(g.start), 1'b0, none);
        end
        else if (pick < 40)
        begin
            send_word(1'($urandom), 21'($urandom), 16'($urandom), 1'b0, none);
        end
        else if (pick < 45)
        begin
            send_word(CMD_ALLOC, 21'($urandom_range(1500, 1048576)), 16'($urandom), 1'b0, none);
        end
        else
        begin
            send_word(CMD_ALLOC, 21'($urandom_range(0, 1500)), 16'($urandom), 1'b0, none);
        end
    endtask

    row_t rows [] = '{
        '{CMD_ALLOC, 21'd0,       16'd0,     1, '{STATUS_ZERO_SIZE, 16'd0, 17'd0}},
        '{CMD_ALLOC, 21'd1,       16'd0,     1, '{STATUS_OK, 16'd0, 17'd1}},
        '{CMD_ALLOC, 21'd8,       16'hFFFF,  1, '{STATUS_OK, 16'd1, 17'd2}},
        '{CMD_ALLOC, 21'd9,       16'd0,     1, '{STATUS_OK, 16'd2, 17'd4}},
        '{CMD_ALLOC, 21'd1048576, 16'd0,     1, '{STATUS_NO_SPACE, 16'd0, 17'd4}},
        '{CMD_ALLOC, 21'h1FFFFF,  16'd0,     1, '{STATUS_NO_SPACE, 16'd0, 17'd4}},
        '{CMD_FREE,  21'd0,       16'hFFFF,  1, '{STATUS_OK, 16'd0, 17'd3}},
        '{CMD_FREE,  21'd8,       16'hFFFF,  1, '{STATUS_OK, 16'd0, 17'd2}},
        '{CMD_FREE,  21'd9,       16'hFFFF,  1, '{STATUS_RANGE, 16'd0, 17'd2}},
        '{CMD_FREE,  21'h1FFFFF,  16'd0,     1, '{STATUS_RANGE, 16'd0, 17'd2}},
        '{CMD_FREE,  21'd1,       16'd0,     1, '{STATUS_OK, 16'd0, 17'd1}},
        '{CMD_FREE,  21'd1,       16'd0,     1, '{STATUS_OK, 16'd0, 17'd0}},
        '{CMD_FREE,  21'd1,       16'd0,     1, '{STATUS_OK, 16'd0, 17'd0}},
        '{CMD_ALLOC, 21'd1000,    16'd0,     0, '{STATUS_OK, 16'd0, 17'd0}},
        '{CMD_ALLOC, 21'd1016,    16'd0,     0, '{STATUS_OK, 16'd0, 17'd0}},
        '{CMD_ALLOC, 21'd24,      16'd0,     0, '{STATUS_OK, 16'd0, 17'd0}},
        '{CMD_ALLOC, 21'd1048568, 16'd0,     0, '{STATUS_OK, 16'd0, 17'd0}},
        '{CMD_FREE,  21'd1000,    16'd0,     0, '{STATUS_OK, 16'd0, 17'd0}},
        '{CMD_ALLOC, 21'd100,     16'd0,     0, '{STATUS_OK, 16'd0, 17'd0}},
        '{CMD_FREE,  21'd1048568, 16'd0,     0, '{STATUS_OK, 16'd0, 17'd0}}
    };

    int phase_heap [] = '{65536, 64, 1, 0, 131071, 200, 65535, 65536};

    initial
    begin
        for (int w = 0; w < MapWords; w++)
        begin
            map_model[w] = '0;
        end
        used_model = 0;
        heap_model = 65536;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (rows[i])
        begin
            send_word(rows[i].cmd, rows[i].bytes, rows[i].block, rows[i].typed, rows[i].res);
        end
        drain();
        live_grants.delete();
        foreach (phase_heap[p])
        begin
            write_heap_blocks(phase_heap[p]);
            calm = (p == 0 || p == 5);
            if (p == 0)
            begin
                stall_request = 1'b1;
            end
            for (int k = 0; k < 56; k++)
            begin
                send_random();
            end
            drain();
        end
        if (errors == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
